// ===== src/mmie_pkg.sv =====
// Shared types and constants of the memory-to-memory instruction executor.
package mmie_pkg;

  localparam int DEFAULT_MEM_WORDS = 1024;
  localparam int DEFAULT_WORD_BITS = 32;

  // Fixed transaction field widths
  localparam int MODE_BITS    = 4;
  localparam int ADDR_IN_BITS = 10;
  localparam int INDEX_BITS   = 10;
  localparam int IMM_BITS     = 32;
  localparam int PRINT_BITS   = 32;

  // Multiplier consumes this many multiplier bits per step
  localparam int MUL_CHUNK_BITS = 16;

  // Instruction classes; encodings match the mode field, OP_NOP covers unused modes
  typedef enum logic [MODE_BITS-1:0] {
    OP_ADD     = 4'd0,
    OP_MUL     = 4'd1,
    OP_SUB     = 4'd2,
    OP_DIV     = 4'd3,
    OP_COPY    = 4'd4,
    OP_LOADIMM = 4'd5,
    OP_JUMP    = 4'd6,
    OP_JUMPIF  = 4'd7,
    OP_LESS    = 4'd8,
    OP_GREATER = 4'd9,
    OP_EQUAL   = 4'd10,
    OP_PRINT   = 4'd11,
    OP_NOP     = 4'd15
  } op_t;

  // Classified instruction as it travels from front end to back end
  typedef struct packed {
    op_t                        op;
    logic signed [IMM_BITS-1:0] imm;
    logic [INDEX_BITS-1:0]      target;
  } cmd_t;

endpackage

// ===== src/mmie_if.sv =====
// Valid/ready channel interfaces for instruction and result transactions.
interface mmie_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [mmie_pkg::MODE_BITS-1:0]        mode;
  logic [mmie_pkg::ADDR_IN_BITS-1:0]     dest;
  logic [mmie_pkg::ADDR_IN_BITS-1:0]     src_a;
  logic [mmie_pkg::ADDR_IN_BITS-1:0]     src_b;
  logic signed [mmie_pkg::IMM_BITS-1:0]  immediate;
  logic [mmie_pkg::INDEX_BITS-1:0]       jump_target;

  modport source (output valid, mode, dest, src_a, src_b, immediate, jump_target,
                  input ready);
  modport sink   (input valid, mode, dest, src_a, src_b, immediate, jump_target,
                  output ready);
endinterface

interface mmie_out_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   print_valid;
  logic signed [mmie_pkg::PRINT_BITS-1:0] print_value;
  logic                                   jump_taken;
  logic [mmie_pkg::INDEX_BITS-1:0]        next_index;
  logic                                   div_by_zero;

  modport source (output valid, print_valid, print_value, jump_taken, next_index,
                  div_by_zero, input ready);
  modport sink   (input valid, print_valid, print_value, jump_taken, next_index,
                  div_by_zero, output ready);
endinterface

// ===== src/mmie_ram.sv =====
// Generic RAM: one write port, two registered read ports.
module mmie_ram #(
  parameter int WIDTH = mmie_pkg::DEFAULT_WORD_BITS,
  parameter int DEPTH = mmie_pkg::DEFAULT_MEM_WORDS,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr_a,
  input  logic [AW-1:0]    rd_addr_b,
  output logic [WIDTH-1:0] rd_data_a,
  output logic [WIDTH-1:0] rd_data_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_a_r;
  logic [WIDTH-1:0] rd_b_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_a_r <= mem_r[rd_addr_a];
    rd_b_r <= mem_r[rd_addr_b];
  end

  assign rd_data_a = rd_a_r;
  assign rd_data_b = rd_b_r;

endmodule

// ===== src/mmie_div.sv =====
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
module mmie_div #(
  parameter int WORD_BITS = mmie_pkg::DEFAULT_WORD_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [WORD_BITS-1:0] dividend,
  input  logic [WORD_BITS-1:0] divisor,
  output logic                 busy,
  output logic [WORD_BITS-1:0] quotient
);

  localparam int CW = $clog2(WORD_BITS);

  logic                 busy_r;
  logic [CW-1:0]        cnt_r;
  logic [WORD_BITS-1:0] rem_r;
  logic [WORD_BITS-1:0] dvd_r;   // dividend magnitude, quotient shifts in from the right
  logic [WORD_BITS-1:0] dsr_r;
  logic                 neg_r;

  logic [WORD_BITS:0]   shifted;
  logic [WORD_BITS:0]   diff;
  logic                 fits;

  assign shifted = {rem_r, dvd_r[WORD_BITS-1]};
  assign fits    = shifted >= {1'b0, dsr_r};
  assign diff    = shifted - {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
    end else if (busy_r && cnt_r == CW'(WORD_BITS - 1)) begin
      busy_r <= 1'b0;
    end

    if (start) begin
      // magnitudes; the most negative word maps to 2^(W-1), which is right unsigned
      dvd_r <= dividend[WORD_BITS-1] ? (~dividend + WORD_BITS'(1)) : dividend;
      dsr_r <= divisor[WORD_BITS-1]  ? (~divisor + WORD_BITS'(1))  : divisor;
      neg_r <= dividend[WORD_BITS-1] ^ divisor[WORD_BITS-1];
      rem_r <= '0;
      cnt_r <= '0;
    end else if (busy_r) begin
      rem_r <= fits ? diff[WORD_BITS-1:0] : shifted[WORD_BITS-1:0];
      dvd_r <= {dvd_r[WORD_BITS-2:0], fits};
      cnt_r <= cnt_r + CW'(1);
    end
  end

  assign busy     = busy_r;
  assign quotient = neg_r ? (~dvd_r + WORD_BITS'(1)) : dvd_r;

endmodule

// ===== src/mmie_front.sv =====
// Front end: accepts instruction transactions, classifies them and queues them.
module mmie_front #(
  parameter int MEM_WORDS = mmie_pkg::DEFAULT_MEM_WORDS,
  localparam int AW       = $clog2(MEM_WORDS)
) (
  input  logic           clk,
  input  logic           rst_n,
  mmie_in_if.sink        in_ch,
  input  logic           accept_en,
  output logic           head_valid,
  input  logic           head_pop,
  output mmie_pkg::cmd_t head_cmd,
  output logic [AW-1:0]  head_dest,
  output logic [AW-1:0]  head_src_a,
  output logic [AW-1:0]  head_src_b
);

  localparam int QDEPTH   = 2;   // power of two, pointers wrap naturally
  localparam int PW       = $clog2(QDEPTH);
  localparam int CW       = $clog2(QDEPTH + 1);
  localparam int IN_SPAN  = 1 << mmie_pkg::ADDR_IN_BITS;
  localparam int MOD_STEPS = (MEM_WORDS >= IN_SPAN) ? 0
                           : $clog2((IN_SPAN + MEM_WORDS - 1) / MEM_WORDS);

  typedef struct packed {
    mmie_pkg::cmd_t cmd;
    logic [AW-1:0]  dest;
    logic [AW-1:0]  src_a;
    logic [AW-1:0]  src_b;
  } entry_t;

  // address modulo the memory size: restoring subtract of shifted multiples
  function automatic logic [AW-1:0] wrap_addr(input logic [mmie_pkg::ADDR_IN_BITS-1:0] a);
    logic [31:0] t;
    t = 32'(a);
    for (int k = MOD_STEPS - 1; k >= 0; k--) begin
      if (t >= (32'(MEM_WORDS) << k)) begin
        t = t - (32'(MEM_WORDS) << k);
      end
    end
    return AW'(t);
  endfunction

  entry_t          q_r [QDEPTH];
  logic [PW-1:0]   wr_ptr_r;
  logic [PW-1:0]   rd_ptr_r;
  logic [CW-1:0]   count_r;
  entry_t          entry_in;
  mmie_pkg::op_t   op_dec;
  logic            push;

  assign op_dec = (in_ch.mode <= mmie_pkg::MODE_BITS'(mmie_pkg::OP_PRINT))
                ? mmie_pkg::op_t'(in_ch.mode) : mmie_pkg::OP_NOP;

  always_comb begin
    entry_in.cmd.op     = op_dec;
    entry_in.cmd.imm    = in_ch.immediate;
    entry_in.cmd.target = in_ch.jump_target;
    entry_in.dest       = wrap_addr(in_ch.dest);
    entry_in.src_a      = wrap_addr(in_ch.src_a);
    entry_in.src_b      = wrap_addr(in_ch.src_b);
  end

  assign in_ch.ready = accept_en && (count_r != CW'(QDEPTH));
  assign push        = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PW'(1);
      end
      if (head_pop) begin
        rd_ptr_r <= rd_ptr_r + PW'(1);
      end
      count_r <= count_r + CW'(push) - CW'(head_pop);
    end
    if (push) begin
      q_r[wr_ptr_r] <= entry_in;
    end
  end

  assign head_valid = count_r != '0;
  assign head_cmd   = q_r[rd_ptr_r].cmd;
  assign head_dest  = q_r[rd_ptr_r].dest;
  assign head_src_a = q_r[rd_ptr_r].src_a;
  assign head_src_b = q_r[rd_ptr_r].src_b;

endmodule

// ===== src/mmie_back.sv =====
// Back end: clears memory after reset, executes queued instructions, holds the result.
module mmie_back #(
  parameter int MEM_WORDS = mmie_pkg::DEFAULT_MEM_WORDS,
  parameter int WORD_BITS = mmie_pkg::DEFAULT_WORD_BITS,
  localparam int AW       = $clog2(MEM_WORDS)
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           head_valid,
  output logic           head_pop,
  input  mmie_pkg::cmd_t head_cmd,
  input  logic [AW-1:0]  head_dest,
  input  logic [AW-1:0]  head_src_a,
  input  logic [AW-1:0]  head_src_b,
  output logic           init_done,
  mmie_out_if.source     out_ch
);

  localparam int CHUNK     = (WORD_BITS < mmie_pkg::MUL_CHUNK_BITS) ? WORD_BITS
                                                                   : mmie_pkg::MUL_CHUNK_BITS;
  localparam int MUL_STEPS = (WORD_BITS + CHUNK - 1) / CHUNK;
  localparam int MCW       = $clog2(MUL_STEPS + 1);

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef enum logic [2:0] {ST_CLEAR, ST_IDLE, ST_EXEC, ST_MUL, ST_DIV} state_t;

  state_t                               state_r, state_nxt;
  logic [AW-1:0]                        clr_cnt_r, clr_cnt_nxt;
  mmie_pkg::op_t                        op_r, op_nxt;
  logic signed [mmie_pkg::IMM_BITS-1:0] imm_r, imm_nxt;
  logic [mmie_pkg::INDEX_BITS-1:0]      target_r, target_nxt;
  logic [AW-1:0]                        dest_r, dest_nxt;
  logic [AW-1:0]                        sa_r, sa_nxt;
  logic [AW-1:0]                        sb_r, sb_nxt;
  logic [WORD_BITS-1:0]                 ma_r, ma_nxt;
  logic [WORD_BITS-1:0]                 mb_r, mb_nxt;
  logic [WORD_BITS-1:0]                 acc_r, acc_nxt;
  logic [MCW-1:0]                       mul_cnt_r, mul_cnt_nxt;
  logic                                 out_valid_r, out_valid_nxt;
  logic                                 pv_r, pv_nxt;
  logic signed [mmie_pkg::PRINT_BITS-1:0] pval_r, pval_nxt;
  logic                                 jt_r, jt_nxt;
  logic [mmie_pkg::INDEX_BITS-1:0]      nx_r, nx_nxt;
  logic                                 dz_r, dz_nxt;

  // memory and divider hookup
  logic                 wr_en;
  logic [AW-1:0]        wr_addr;
  logic [WORD_BITS-1:0] wr_data;
  logic [AW-1:0]        rd_addr_a, rd_addr_b;
  word_t                rd_a, rd_b;
  logic                 div_start, div_busy;
  logic [WORD_BITS-1:0] div_q;

  // combinational execute results
  logic                                   ex_wr;
  logic [WORD_BITS-1:0]                   ex_data;
  logic                                   ex_pv;
  logic signed [mmie_pkg::PRINT_BITS-1:0] ex_pval;
  logic                                   ex_jt;

  logic                 out_free;
  logic [WORD_BITS-1:0] chunk_ext;
  logic [WORD_BITS-1:0] mul_lo;

  mmie_ram #(.WIDTH(WORD_BITS), .DEPTH(MEM_WORDS)) u_ram (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_a),
    .rd_data_b (rd_b)
  );

  mmie_div #(.WORD_BITS(WORD_BITS)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (rd_a),
    .divisor  (rd_b),
    .busy     (div_busy),
    .quotient (div_q)
  );

  assign out_free  = !out_valid_r || out_ch.ready;
  assign init_done = state_r != ST_CLEAR;

  // read addresses come straight from the queue head while idle, then stay put
  assign rd_addr_a = (state_r == ST_IDLE) ? head_src_a : sa_r;
  assign rd_addr_b = (state_r == ST_IDLE) ? head_src_b : sb_r;

  // one chunk of the multiplier per step; upper bits of chunk_ext are zero
  assign chunk_ext = WORD_BITS'(mb_r[CHUNK-1:0]);
  assign mul_lo    = ma_r * chunk_ext;

  always_comb begin : exec_decode
    ex_wr   = 1'b0;
    ex_data = '0;
    ex_pv   = 1'b0;
    ex_pval = '0;
    ex_jt   = 1'b0;
    unique case (op_r)
      mmie_pkg::OP_ADD:     begin ex_wr = 1'b1; ex_data = rd_a + rd_b; end
      mmie_pkg::OP_SUB:     begin ex_wr = 1'b1; ex_data = rd_a - rd_b; end
      mmie_pkg::OP_COPY:    begin ex_wr = 1'b1; ex_data = rd_a; end
      mmie_pkg::OP_LOADIMM: begin ex_wr = 1'b1; ex_data = WORD_BITS'(imm_r); end
      mmie_pkg::OP_LESS:    begin ex_wr = 1'b1; ex_data = WORD_BITS'(rd_a < rd_b); end
      mmie_pkg::OP_GREATER: begin ex_wr = 1'b1; ex_data = WORD_BITS'(rd_b < rd_a); end
      mmie_pkg::OP_EQUAL:   begin ex_wr = 1'b1; ex_data = WORD_BITS'(rd_a == rd_b); end
      mmie_pkg::OP_JUMP:    ex_jt = 1'b1;
      mmie_pkg::OP_JUMPIF:  ex_jt = (rd_a == word_t'(1));
      mmie_pkg::OP_PRINT:   begin ex_pv = 1'b1; ex_pval = mmie_pkg::PRINT_BITS'(rd_a); end
      mmie_pkg::OP_MUL, mmie_pkg::OP_DIV, mmie_pkg::OP_NOP: ;
      default: ;
    endcase
  end

  always_comb begin : fsm_next
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    op_nxt        = op_r;
    imm_nxt       = imm_r;
    target_nxt    = target_r;
    dest_nxt      = dest_r;
    sa_nxt        = sa_r;
    sb_nxt        = sb_r;
    ma_nxt        = ma_r;
    mb_nxt        = mb_r;
    acc_nxt       = acc_r;
    mul_cnt_nxt   = mul_cnt_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    pv_nxt        = pv_r;
    pval_nxt      = pval_r;
    jt_nxt        = jt_r;
    nx_nxt        = nx_r;
    dz_nxt        = dz_r;
    wr_en         = 1'b0;
    wr_addr       = dest_r;
    wr_data       = '0;
    head_pop      = 1'b0;
    div_start     = 1'b0;

    unique case (state_r)
      ST_CLEAR: begin
        wr_en       = 1'b1;
        wr_addr     = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + AW'(1);
        if (clr_cnt_r == AW'(MEM_WORDS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (head_valid) begin
          head_pop   = 1'b1;
          op_nxt     = head_cmd.op;
          imm_nxt    = head_cmd.imm;
          target_nxt = head_cmd.target;
          dest_nxt   = head_dest;
          sa_nxt     = head_src_a;
          sb_nxt     = head_src_b;
          state_nxt  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (op_r == mmie_pkg::OP_MUL) begin
          ma_nxt      = rd_a;
          mb_nxt      = rd_b;
          acc_nxt     = '0;
          mul_cnt_nxt = '0;
          state_nxt   = ST_MUL;
        end else if (op_r == mmie_pkg::OP_DIV && rd_b != '0) begin
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end else if (out_free) begin
          // zero divisor lands here too: no write, flag only
          wr_en         = ex_wr;
          wr_data       = ex_data;
          out_valid_nxt = 1'b1;
          pv_nxt        = ex_pv;
          pval_nxt      = ex_pval;
          jt_nxt        = ex_jt;
          nx_nxt        = ex_jt ? target_r : '0;
          dz_nxt        = op_r == mmie_pkg::OP_DIV;
          state_nxt     = ST_IDLE;
        end
      end
      ST_MUL: begin
        if (mul_cnt_r != MCW'(MUL_STEPS)) begin
          acc_nxt     = acc_r + mul_lo;
          ma_nxt      = ma_r << CHUNK;
          mb_nxt      = mb_r >> CHUNK;
          mul_cnt_nxt = mul_cnt_r + MCW'(1);
        end else if (out_free) begin
          wr_en         = 1'b1;
          wr_data       = acc_r;
          out_valid_nxt = 1'b1;
          pv_nxt        = 1'b0;
          pval_nxt      = '0;
          jt_nxt        = 1'b0;
          nx_nxt        = '0;
          dz_nxt        = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      ST_DIV: begin
        if (!div_busy && out_free) begin
          wr_en         = 1'b1;
          wr_data       = div_q;
          out_valid_nxt = 1'b1;
          pv_nxt        = 1'b0;
          pval_nxt      = '0;
          jt_nxt        = 1'b0;
          nx_nxt        = '0;
          dz_nxt        = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r      <= op_nxt;
    imm_r     <= imm_nxt;
    target_r  <= target_nxt;
    dest_r    <= dest_nxt;
    sa_r      <= sa_nxt;
    sb_r      <= sb_nxt;
    ma_r      <= ma_nxt;
    mb_r      <= mb_nxt;
    acc_r     <= acc_nxt;
    mul_cnt_r <= mul_cnt_nxt;
    pv_r      <= pv_nxt;
    pval_r    <= pval_nxt;
    jt_r      <= jt_nxt;
    nx_r      <= nx_nxt;
    dz_r      <= dz_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.print_valid = pv_r;
  assign out_ch.print_value = pval_r;
  assign out_ch.jump_taken  = jt_r;
  assign out_ch.next_index  = nx_r;
  assign out_ch.div_by_zero = dz_r;

endmodule

// ===== src/memory_to_memory_instruction_executor_top.sv =====
// Top level of the memory-to-memory instruction executor.
//
// Executes one decoded instruction per input transaction against a memory of
// MEM_WORDS signed words of WORD_BITS bits, and returns exactly one result
// transaction per instruction, in order. Operand addresses are reduced modulo
// MEM_WORDS. After reset the block sweeps the memory to zero, one word per
// cycle, so in_ch.ready stays low until the sweep is done. A front end
// classifies instructions into a two-entry queue; the back end executes them
// one at a time. Most instructions pop the queue and issue both operand reads
// on the two read ports of the word memory, then compute, write back and load
// the result register. Multiply runs ceil(WORD_BITS/16) extra steps through a
// 16-bit-chunk multiplier before its write-back. Divide uses a radix-2 iterative
// divider; a zero divisor skips the divider. A result waits in the output
// register while the next instruction executes; it stalls only at its own
// write-back.
module memory_to_memory_instruction_executor_top #(
  parameter int MEM_WORDS = mmie_pkg::DEFAULT_MEM_WORDS,
  parameter int WORD_BITS = mmie_pkg::DEFAULT_WORD_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  mmie_in_if.sink     in_ch,
  mmie_out_if.source  out_ch
);

  localparam int AW = $clog2(MEM_WORDS);

  logic           init_done;
  logic           head_valid;
  logic           head_pop;
  mmie_pkg::cmd_t head_cmd;
  logic [AW-1:0]  head_dest;
  logic [AW-1:0]  head_src_a;
  logic [AW-1:0]  head_src_b;

  mmie_front #(.MEM_WORDS(MEM_WORDS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .accept_en  (init_done),
    .head_valid (head_valid),
    .head_pop   (head_pop),
    .head_cmd   (head_cmd),
    .head_dest  (head_dest),
    .head_src_a (head_src_a),
    .head_src_b (head_src_b)
  );

  mmie_back #(.MEM_WORDS(MEM_WORDS), .WORD_BITS(WORD_BITS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_pop   (head_pop),
    .head_cmd   (head_cmd),
    .head_dest  (head_dest),
    .head_src_a (head_src_a),
    .head_src_b (head_src_b),
    .init_done  (init_done),
    .out_ch     (out_ch)
  );

  // no transaction taken while the clearing sweep is still running
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !init_done |-> !in_ch.ready)
    else $error("instruction accepted during memory clear");

  // clearing finishes once and never restarts
  a_init_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    init_done |=> init_done)
    else $error("memory clear restarted");

  // back end only pops a queue entry that exists
  a_pop_has_entry: assert property (@(posedge clk) disable iff (!rst_n)
    head_pop |-> head_valid)
    else $error("queue popped while empty");

  // a result carries at most one kind of report, and no target unless jumping
  a_result_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> ($countones({out_ch.print_valid, out_ch.jump_taken,
                                  out_ch.div_by_zero}) <= 1)
                     && (out_ch.jump_taken || out_ch.next_index == '0))
    else $error("inconsistent result transaction");

endmodule
